@@ rtl/core/lvsa_pkg.sv @@
// Shared constants, codes and control types of the voice slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package lvsa_pkg;

  // Field widths of request and response beats
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 5;
  localparam int COUNT_W   = 6;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  // Default pool size
  localparam int SLOTS_DEF = 32;

  // Request command codes; the fourth code is ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_PLAY     = 2'd0,
    CMD_FINISH   = 2'd1,
    CMD_STOP_ALL = 2'd2
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request beat
    logic lookup;  // read rank of the finished slot, arm the sweep
    logic sweep;   // walk the rank memory
    logic commit;  // update busy map and count, register the result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_play;     // captured command is a play request
    logic fin_hit;     // captured finish names a busy slot
    logic sweep_done;  // last rank entry processed
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/lvsa_req_if.sv @@
// Request channel: valid/ready handshake with command, slot and started flag.
`timescale 1ns / 1ps
`default_nettype none
interface lvsa_req_if;
  import lvsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic              started;

  modport source (output valid, output command, output slot, output started, input ready);
  modport sink   (input valid, input command, input slot, input started, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lvsa_rsp_if.sv @@
// Response channel: valid/ready handshake with the allocation result.
`timescale 1ns / 1ps
`default_nettype none
interface lvsa_rsp_if;
  import lvsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  chosen_slot;
  logic               stole_oldest;
  logic               now_busy;
  logic [COUNT_W-1:0] active_count;

  modport source (output valid, output chosen_slot, output stole_oldest, output now_busy,
                  output active_count, input ready);
  modport sink   (input valid, input chosen_slot, input stole_oldest, input now_busy,
                  input active_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lvsa_ctrl.sv @@
// Controller: sequences lookup, rank sweep and commit for one request beat.
`timescale 1ns / 1ps
`default_nettype none
module lvsa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire logic              rsp_ready_i,
  output logic                   rsp_valid_o,
  input  wire lvsa_pkg::dp_sts_t sts_i,
  output lvsa_pkg::dp_cmd_t      cmd_o
);
  import lvsa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new beat when empty or draining
  assign out_free = !out_valid_q || rsp_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        if (sts_i.is_play || sts_i.fin_hit) begin
          state_d = ST_SWEEP;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set output valid on commit, drop it when the beat is taken
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/lvsa_dp.sv @@
// Datapath: busy map, per-slot recency rank memory, busy count and result register.
`timescale 1ns / 1ps
`default_nettype none
module lvsa_dp #(
  parameter int SLOTS = lvsa_pkg::SLOTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lvsa_pkg::dp_cmd_t              cmd_i,
  input  wire logic [lvsa_pkg::CMD_W-1:0]     command_i,
  input  wire logic [lvsa_pkg::SLOT_W-1:0]    slot_i,
  input  wire logic                           started_i,
  output lvsa_pkg::dp_sts_t                   sts_o,
  output logic      [lvsa_pkg::SLOT_W-1:0]    chosen_slot_o,
  output logic                                stole_oldest_o,
  output logic                                now_busy_o,
  output logic      [lvsa_pkg::COUNT_W-1:0]   active_count_o
);
  import lvsa_pkg::*;

  localparam int AW = $clog2(SLOTS);      // slot index / rank width
  localparam int CW = $clog2(SLOTS + 1);  // count width, holds SLOTS
  localparam int XW = AW + SLOT_W;        // common width for slot compares
  localparam int KW = CW + COUNT_W;       // common width for count saturation

  // Rank of each busy slot: 0 is the most recently started voice
  logic [AW-1:0] rank_mem [SLOTS];
  logic [AW-1:0] rd_data_q;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_wdata;

  logic [SLOTS-1:0] busy_q;
  logic [CW-1:0]    len_q, len_d;

  // Captured request beat
  logic [CMD_W-1:0]  cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic              started_q;

  // Sweep bookkeeping
  logic [CW-1:0] idx_q;
  logic          idx_live;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic          ref_load_q;
  logic [AW-1:0] ref_rank_q;
  logic          free_found_q;
  logic [AW-1:0] free_idx_q;
  logic [AW-1:0] victim_idx_q;
  logic          victim_hit;

  logic          is_play;
  logic [XW-1:0] slot_wide;
  logic [AW-1:0] slot_idx;
  logic          slot_in_range;
  logic          fin_hit;
  logic [AW-1:0] s_idx;
  logic [XW-1:0] s_wide;
  logic          stole;
  logic [KW-1:0] count_wide;

  logic [SLOT_W-1:0]  chosen_d;
  logic               stole_d;
  logic               now_busy_d;
  logic [COUNT_W-1:0] active_d;

  // Decode captured beat
  assign is_play       = (cmd_q == CMD_PLAY);
  assign slot_wide     = XW'(slot_q);
  assign slot_in_range = slot_wide < XW'(SLOTS);
  assign slot_idx      = slot_in_range ? slot_wide[AW-1:0] : '0;
  assign fin_hit       = (cmd_q == CMD_FINISH) && slot_in_range && busy_q[slot_idx];

  assign idx_live   = idx_q < CW'(SLOTS);
  assign victim_hit = (CW'(rd_data_q) == (len_q - CW'(1)));

  // Play target: lowest free slot, else the oldest voice
  assign s_idx  = free_found_q ? free_idx_q : victim_idx_q;
  assign stole  = !free_found_q;
  assign s_wide = XW'(s_idx);

  assign sts_o.is_play    = is_play;
  assign sts_o.fin_hit    = fin_hit;
  assign sts_o.sweep_done = !idx_live && !rd_vld_q;

  // Read port: finished slot during lookup, sweep index otherwise
  assign mem_raddr = cmd_i.lookup ? slot_idx : (idx_live ? idx_q[AW-1:0] : '0);

  // Write port: rank update during sweep, new front entry on commit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx_q;
    mem_wdata = rd_data_q + AW'(1);
    if (cmd_i.commit) begin
      if (is_play && started_q) begin
        mem_we    = 1'b1;
        mem_waddr = s_idx;
        mem_wdata = '0;
      end
    end else if (rd_vld_q) begin
      if (is_play) begin
        mem_we = started_q;
      end else begin
        mem_we    = busy_q[rd_idx_q] && (rd_data_q > ref_rank_q);
        mem_wdata = rd_data_q - AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rank_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= rank_mem[mem_raddr];
  end

  // Next count and result fields
  always_comb begin
    len_d      = len_q;
    chosen_d   = '0;
    stole_d    = 1'b0;
    now_busy_d = 1'b0;
    unique case (cmd_q)
      CMD_PLAY: begin
        chosen_d   = s_wide[SLOT_W-1:0];
        stole_d    = stole;
        now_busy_d = started_q;
        if (started_q && !stole) begin
          len_d = len_q + CW'(1);
        end else if (!started_q && stole) begin
          len_d = len_q - CW'(1);
        end
      end
      CMD_FINISH: begin
        chosen_d = slot_q;
        if (fin_hit) begin
          len_d = len_q - CW'(1);
        end
      end
      CMD_STOP_ALL: len_d = '0;
      default:      len_d = len_q;
    endcase
  end

  // Saturate the count to the field width
  assign count_wide = KW'(len_d);
  assign active_d   = (count_wide > KW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                    : count_wide[COUNT_W-1:0];

  // Busy map, count and sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      len_q      <= '0;
      idx_q      <= '0;
      rd_vld_q   <= 1'b0;
      ref_load_q <= 1'b0;
    end else begin
      ref_load_q <= cmd_i.lookup;
      if (cmd_i.lookup) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        rd_vld_q <= cmd_i.sweep && idx_live;
        if (cmd_i.sweep && idx_live) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (cmd_i.commit) begin
        len_q <= len_d;
        unique case (cmd_q)
          CMD_PLAY: busy_q[s_idx] <= started_q;
          CMD_FINISH: begin
            if (fin_hit) begin
              busy_q[slot_idx] <= 1'b0;
            end
          end
          CMD_STOP_ALL: busy_q <= '0;
          default:      busy_q <= busy_q;
        endcase
      end
    end
  end

  // Beat capture, sweep scan results and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= command_i;
      slot_q    <= slot_i;
      started_q <= started_i;
    end
    rd_idx_q <= idx_live ? idx_q[AW-1:0] : '0;
    if (ref_load_q) begin
      ref_rank_q <= rd_data_q;
    end
    if (cmd_i.lookup) begin
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      victim_idx_q <= '0;
    end else if (rd_vld_q && is_play) begin
      if (!busy_q[rd_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
      if (busy_q[rd_idx_q] && victim_hit) begin
        victim_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.commit) begin
      chosen_slot_o  <= chosen_d;
      stole_oldest_o <= stole_d;
      now_busy_o     <= now_busy_d;
      active_count_o <= active_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lru_voice_slot_allocator.sv @@
// Top level of the LRU voice slot allocator: controller, datapath and channel ports.
// Sequence: accept, lookup, a sweep through the rank memory read port, then commit for a play
//   or a finish on a busy slot; accept, lookup and commit otherwise.
// Throughput: one beat at a time; commit stalls while the previous result still waits on
//   the response channel.
// Reset: asynchronous, active low; all slots free, count zero, rank memory not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lru_voice_slot_allocator #(
  parameter int SLOTS = lvsa_pkg::SLOTS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lvsa_req_if.sink    req_i,
  lvsa_rsp_if.source  rsp_o
);
  import lvsa_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer
  lvsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Slot state and result
  lvsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .command_i      (req_i.command),
    .slot_i         (req_i.slot),
    .started_i      (req_i.started),
    .sts_o          (dp_sts),
    .chosen_slot_o  (rsp_o.chosen_slot),
    .stole_oldest_o (rsp_o.stole_oldest),
    .now_busy_o     (rsp_o.now_busy),
    .active_count_o (rsp_o.active_count)
  );

endmodule
`default_nettype wire

@@ rtl/core/lvsa_checker.sv @@
// Port-level checks for the voice slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lvsa_checker #(
  parameter int SLOTS = lvsa_pkg::SLOTS_DEF
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           req_valid_i,
  input wire logic                           req_ready_i,
  input wire logic                           rsp_valid_i,
  input wire logic                           rsp_ready_i,
  input wire logic [lvsa_pkg::SLOT_W-1:0]    chosen_slot_i,
  input wire logic                           stole_oldest_i,
  input wire logic                           now_busy_i,
  input wire logic [lvsa_pkg::COUNT_W-1:0]   active_count_i
);
  import lvsa_pkg::*;

  localparam int CNT_CAP = (SLOTS > COUNT_MAX) ? COUNT_MAX : SLOTS;

  // One beat in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while a beat is in flight");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({chosen_slot_i, stole_oldest_i, now_busy_i, active_count_i}))
    else $error("stalled result changed");

  // Count never exceeds the pool
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> active_count_i <= COUNT_W'(CNT_CAP))
    else $error("active count above pool size");

  // Stealing only happens on a full pool, which stays full when the voice starts
  a_steal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && stole_oldest_i && now_busy_i |-> active_count_i == COUNT_W'(CNT_CAP))
    else $error("steal without a full pool");

  // A started voice leaves at least one busy slot
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && now_busy_i |-> active_count_i != '0)
    else $error("started voice with zero active count");

endmodule

bind lru_voice_slot_allocator lvsa_checker #(.SLOTS(SLOTS)) u_lvsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .chosen_slot_i  (rsp_o.chosen_slot),
  .stole_oldest_i (rsp_o.stole_oldest),
  .now_busy_i     (rsp_o.now_busy),
  .active_count_i (rsp_o.active_count)
);
`default_nettype wire
